// ===== src/mcls_pkg.sv =====
// Shared types, field widths, register indexes and state codes for the
// motion state classifier. No dependencies.
package mcls_pkg;

   localparam int ACC_W   = 16;
   localparam int ANG_W   = 16;
   localparam int VIB_W   = 17;
   localparam int TILT_W  = 15;
   localparam int BOX_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam int DIFF_W  = 16;
   localparam int SQ_W    = 32;
   localparam int RAD_W   = 36;
   localparam int ROOT_W  = 18;
   localparam int REM_W   = 20;
   localparam int ROOT_CYCLES = 9;
   localparam int ROOT_CNT_W  = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_VIB_THR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_THR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_THR = 2'd2;

   localparam logic [VIB_W-1:0]         VIB_THR_RESET  = 17'd1024;
   localparam logic [TILT_W-1:0]        TILT_THR_RESET = 15'd3000;
   localparam logic signed [ACC_W-1:0]  OPEN_THR_RESET = 16'sd1434;

   localparam logic [BOX_W-1:0] BOX_CLOSED = 2'd0;
   localparam logic [BOX_W-1:0] BOX_OPENED = 2'd1;
   localparam logic [BOX_W-1:0] BOX_MOVING = 2'd2;
   localparam logic [BOX_W-1:0] BOX_TILTED = 2'd3;

   typedef struct packed {
      logic signed [ACC_W-1:0] x;
      logic signed [ACC_W-1:0] y;
      logic signed [ACC_W-1:0] z;
   } sample_type;

endpackage

// ===== src/mcls_if.sv =====
// Valid/ready channel interfaces for sample words, result words and
// register writes. Depends on mcls_pkg.
interface mcls_req_if;
   import mcls_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [ACC_W-1:0]  acc_x;
   logic signed [ACC_W-1:0]  acc_y;
   logic signed [ACC_W-1:0]  acc_z;
   logic signed [ANG_W-1:0]  pitch_angle;
   logic signed [ANG_W-1:0]  roll_angle;
   modport source (output valid, acc_x, acc_y, acc_z, pitch_angle, roll_angle,
                   input ready);
   modport sink   (input valid, acc_x, acc_y, acc_z, pitch_angle, roll_angle,
                   output ready);
endinterface

interface mcls_rsp_if;
   import mcls_pkg::*;
   logic              valid;
   logic              ready;
   logic [VIB_W-1:0]  vibration;
   logic [BOX_W-1:0]  box_state;
   modport source (output valid, vibration, box_state, input ready);
   modport sink   (input valid, vibration, box_state, output ready);
endinterface

interface mcls_csr_if;
   import mcls_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/vibration_motion_state_classifier.sv =====
// Motion state classifier top level: sequencer, threshold registers and
// result register. Depends on mcls_pkg, mcls_if, mcls_ring, mcls_dist, mcls_div.
//
// req_bus carries one motion sample per word; rsp_bus returns one word per
// sample with the vibration estimate and the box state; csr_bus writes the
// three thresholds (index 0 vibration, 1 tilt, 2 open) and is ready out of reset.
// A sample is taken only while the sequencer is idle. Its acceleration is
// stored in the history memory, then the held samples are read back one per
// pair, newest first; each pair goes through the distance unit (difference,
// squares, sum, then a root at two bits per cycle). The sum of roots is
// divided by the pair count in a one-bit-per-cycle divider. With one sample
// held the sequencer goes straight to the result. The sequencer takes no
// new sample while it works on one; the next sample can be taken in the
// cycle after the result loads. The result register frees the sequencer: a
// new sample is taken while a result waits; the next result then waits until
// rsp_bus.ready takes the old one. Reset clears the thresholds to their
// defaults, empties the history and drops any pending result. The history
// memory has no clearing pass: only written entries are ever read.
module vibration_motion_state_classifier #(
   parameter int HISTORY_DEPTH = 10
) (
   input  logic               clock,
   input  logic               reset,
   mcls_req_if.sink           req_bus,
   mcls_rsp_if.source         rsp_bus,
   mcls_csr_if.sink           csr_bus
);
   import mcls_pkg::*;

   localparam int PTR_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W = VIB_W + $clog2(HISTORY_DEPTH);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_DIST  = 3'd2;
   localparam logic [2:0] S_ROOT  = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_DWAIT = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   logic [2:0]               state_ff, state_in;
   logic [PTR_W-1:0]         wp_ff, wp_in;
   logic [CNT_W-1:0]         held_ff, held_in;
   logic [CNT_W-1:0]         pairs_ff;
   logic [PTR_W-1:0]         rd_addr_ff;
   logic [SUM_W-1:0]         sum_ff;
   logic [VIB_W-1:0]         vib_ff;
   sample_type               prev_ff;
   sample_type               in_sample;
   sample_type               rd_sample;
   logic signed [ACC_W-1:0]  az_ff;
   logic signed [ANG_W-1:0]  pitch_ff;
   logic signed [ANG_W-1:0]  roll_ff;

   logic [VIB_W-1:0]         vib_thr_ff;
   logic [TILT_W-1:0]        tilt_thr_ff;
   logic signed [ACC_W-1:0]  open_thr_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VIB_W-1:0]         rsp_vib_ff;
   logic [BOX_W-1:0]         rsp_box_ff;

   logic                     accept;
   logic                     load_rsp;
   logic                     dist_done;
   logic [VIB_W-1:0]         dist_root;
   logic                     div_done;
   logic [VIB_W-1:0]         div_quo;
   logic [ANG_W:0]           pitch_mag;
   logic [ANG_W:0]           roll_mag;
   logic [BOX_W-1:0]         box;

   assign req_bus.ready = (state_ff == S_IDLE) && !reset;
   assign accept        = req_bus.valid && req_bus.ready;
   assign load_rsp      = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_bus.ready);
   assign in_sample     = '{x: req_bus.acc_x, y: req_bus.acc_y, z: req_bus.acc_z};

   mcls_ring #(
      .DEPTH (HISTORY_DEPTH),
      .PTR_W (PTR_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wp_ff),
      .wr_data (in_sample),
      .rd_en   (state_ff == S_READ),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_sample)
   );

   mcls_dist u_dist (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_DIST),
      .newer (prev_ff),
      .older (rd_sample),
      .done  (dist_done),
      .root  (dist_root)
   );

   mcls_div #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_DIV),
      .num   (sum_ff),
      .den   (held_ff - 1'b1),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      wp_in   = (wp_ff == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      held_in = (held_ff == CNT_W'(HISTORY_DEPTH)) ? held_ff : held_ff + 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (held_in < CNT_W'(2)) ? S_FIN : S_READ;
            end
         end
         S_READ:  state_in = S_DIST;
         S_DIST:  state_in = S_ROOT;
         S_ROOT: begin
            if (dist_done) begin
               state_in = (pairs_ff + 1'b1 == held_ff - 1'b1) ? S_DIV : S_READ;
            end
         end
         S_DIV:   state_in = S_DWAIT;
         S_DWAIT: if (div_done) state_in = S_FIN;
         S_FIN:   if (load_rsp) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wp_ff    <= '0;
         held_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            wp_ff   <= wp_in;
            held_ff <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prev_ff    <= in_sample;
         az_ff      <= req_bus.acc_z;
         pitch_ff   <= req_bus.pitch_angle;
         roll_ff    <= req_bus.roll_angle;
         rd_addr_ff <= (wp_ff == '0) ? PTR_W'(HISTORY_DEPTH - 1) : wp_ff - 1'b1;
         pairs_ff   <= '0;
         sum_ff     <= '0;
         vib_ff     <= '0;
      end
      if (state_ff == S_DIST) begin
         prev_ff <= rd_sample;
      end
      if (state_ff == S_ROOT && dist_done) begin
         sum_ff     <= sum_ff + SUM_W'(dist_root);
         pairs_ff   <= pairs_ff + 1'b1;
         rd_addr_ff <= (rd_addr_ff == '0) ? PTR_W'(HISTORY_DEPTH - 1) : rd_addr_ff - 1'b1;
      end
      if (state_ff == S_DWAIT && div_done) begin
         vib_ff <= div_quo;
      end
   end

   // register writes; unknown indexes are dropped
   assign csr_bus.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         vib_thr_ff  <= VIB_THR_RESET;
         tilt_thr_ff <= TILT_THR_RESET;
         open_thr_ff <= OPEN_THR_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            CSR_VIB_THR:  vib_thr_ff  <= csr_bus.data[VIB_W-1:0];
            CSR_TILT_THR: tilt_thr_ff <= csr_bus.data[TILT_W-1:0];
            CSR_OPEN_THR: open_thr_ff <= csr_bus.data[ACC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pitch_mag = pitch_ff[ANG_W-1] ? -{pitch_ff[ANG_W-1], pitch_ff}
                                    : {pitch_ff[ANG_W-1], pitch_ff};
      roll_mag  = roll_ff[ANG_W-1] ? -{roll_ff[ANG_W-1], roll_ff}
                                   : {roll_ff[ANG_W-1], roll_ff};
      priority if (vib_ff > vib_thr_ff) begin
         box = BOX_MOVING;
      end else if (pitch_mag > (ANG_W+1)'(tilt_thr_ff) ||
                   roll_mag > (ANG_W+1)'(tilt_thr_ff)) begin
         box = BOX_TILTED;
      end else if (az_ff < open_thr_ff) begin
         box = BOX_OPENED;
      end else begin
         box = BOX_CLOSED;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_vib_ff <= vib_ff;
         rsp_box_ff <= box;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.vibration = rsp_vib_ff;
   assign rsp_bus.box_state = rsp_box_ff;

endmodule

// ===== src/mcls_ring.sv =====
// Sample history memory: one write port, one read port, registered read data.
// Depends on mcls_pkg.
module mcls_ring #(
   parameter int DEPTH = 10,
   parameter int PTR_W = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [PTR_W-1:0]     wr_addr,
   input  mcls_pkg::sample_type wr_data,
   input  logic                 rd_en,
   input  logic [PTR_W-1:0]     rd_addr,
   output mcls_pkg::sample_type rd_data
);
   import mcls_pkg::*;

   sample_type mem [DEPTH];
   sample_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mcls_dist.sv =====
// Distance unit: squared Euclidean difference of two samples, then floored
// square root two bits per cycle. Depends on mcls_pkg.
module mcls_dist (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  mcls_pkg::sample_type         newer,
   input  mcls_pkg::sample_type         older,
   output logic                         done,
   output logic [mcls_pkg::VIB_W-1:0]   root
);
   import mcls_pkg::*;

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_SQ   = 2'd1;
   localparam logic [1:0] D_SUM  = 2'd2;
   localparam logic [1:0] D_ROOT = 2'd3;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } root_acc_type;

   logic [1:0]             state_ff, state_in;
   logic [DIFF_W-1:0]      ad_ff [3];
   logic [SQ_W-1:0]        sq_ff [3];
   logic [RAD_W-1:0]       rad_ff;
   logic [REM_W-1:0]       rem_ff;
   logic [ROOT_W-1:0]      root_ff;
   logic [ROOT_CNT_W-1:0]  step_ff;
   logic                   done_ff, done_in;
   root_acc_type           mid, fin;

   function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [ACC_W-1:0] a,
                                                  input logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0] d;
      d = {a[ACC_W-1], a} - {b[ACC_W-1], b};
      if (d[ACC_W]) begin
         d = -d;
      end
      return d[DIFF_W-1:0];
   endfunction

   function automatic root_acc_type root_step(input root_acc_type acc, input logic [1:0] pair);
      logic [REM_W+1:0]  remx;
      logic [REM_W+1:0]  trial;
      root_acc_type      res;
      remx  = {acc.rem, pair};
      trial = {2'b00, acc.root, 2'b01};
      if (remx >= trial) begin
         res.rem  = REM_W'(remx - trial);
         res.root = {acc.root[ROOT_W-2:0], 1'b1};
      end else begin
         res.rem  = remx[REM_W-1:0];
         res.root = {acc.root[ROOT_W-2:0], 1'b0};
      end
      return res;
   endfunction

   always_comb begin
      mid = root_step('{rem: rem_ff, root: root_ff}, rad_ff[RAD_W-1 -: 2]);
      fin = root_step(mid, rad_ff[RAD_W-3 -: 2]);
   end

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         D_IDLE: if (start) state_in = D_SQ;
         D_SQ:   state_in = D_SUM;
         D_SUM:  state_in = D_ROOT;
         D_ROOT: begin
            if (step_ff == ROOT_CNT_W'(ROOT_CYCLES - 1)) begin
               state_in = D_IDLE;
               done_in  = 1'b1;
            end
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         D_IDLE: begin
            ad_ff[0] <= abs_diff(newer.x, older.x);
            ad_ff[1] <= abs_diff(newer.y, older.y);
            ad_ff[2] <= abs_diff(newer.z, older.z);
         end
         D_SQ: begin
            sq_ff[0] <= ad_ff[0] * ad_ff[0];
            sq_ff[1] <= ad_ff[1] * ad_ff[1];
            sq_ff[2] <= ad_ff[2] * ad_ff[2];
         end
         D_SUM: begin
            rad_ff  <= RAD_W'(sq_ff[0]) + RAD_W'(sq_ff[1]) + RAD_W'(sq_ff[2]);
            rem_ff  <= '0;
            root_ff <= '0;
            step_ff <= '0;
         end
         D_ROOT: begin
            rad_ff  <= {rad_ff[RAD_W-5:0], 4'b0000};
            rem_ff  <= fin.rem;
            root_ff <= fin.root;
            step_ff <= step_ff + 1'b1;
         end
         default: ;
      endcase
   end

   assign done = done_ff;
   assign root = root_ff[VIB_W-1:0];

endmodule

// ===== src/mcls_div.sv =====
// Restoring divider, one quotient bit per cycle, for the distance mean.
// Depends on mcls_pkg.
module mcls_div #(
   parameter int NUM_W = 21,
   parameter int DEN_W = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [NUM_W-1:0]            num,
   input  logic [DEN_W-1:0]            den,
   output logic                        done,
   output logic [mcls_pkg::VIB_W-1:0]  quo
);
   import mcls_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);

   logic [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    shifted;
   logic              take;

   assign shifted = {rem_ff, num_ff[NUM_W-1]};
   assign take    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff && cnt_ff == CNT_W'(NUM_W - 1)) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= take ? DEN_W'(shifted - {1'b0, den_ff}) : shifted[DEN_W-1:0];
         num_ff <= {num_ff[NUM_W-2:0], take};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign done = done_ff;
   assign quo  = num_ff[VIB_W-1:0];

endmodule

// ===== src/mcls_checker.sv =====
// Port-level checks for the motion state classifier, bound to its top level.
// Depends on mcls_pkg and vibration_motion_state_classifier.
module mcls_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [mcls_pkg::VIB_W-1:0]   rsp_vibration,
   input logic [mcls_pkg::BOX_W-1:0]   rsp_box_state
);
   import mcls_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample word taken while busy");

   a_moving_vib: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_box_state == BOX_MOVING |-> rsp_vibration != '0)
      else $error("moving reported with zero vibration");

endmodule

bind vibration_motion_state_classifier mcls_checker u_mcls_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_vibration (rsp_bus.vibration),
   .rsp_box_state (rsp_bus.box_state)
);
